@@ rtl/pmlm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmlm_pkg
// shared constants, codes and types of the priority mutex lock manager
// ----------------------------------------------------------------------------
package pmlm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LOCKS   = 3;

  localparam int ID_W    = 8;
  localparam int PRI_W   = 8;
  localparam int LID_W   = 2;
  localparam int LEFT_W  = 5;
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LOCK_W  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int ENTRIES = NUM_LOCKS * QUEUE_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_ACQUIRED   = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_FULL       = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_HANDOVER   = 3'd4,
    ST_NOT_HOLDER = 3'd5,
    ST_INVALID    = 3'd6
  } status_e;

  typedef enum logic {
    REQ_WAIT   = 1'b0,
    REQ_SIGNAL = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [PRI_W-1:0] proc_priority;
    logic [ID_W-1:0]  proc_id;
    logic [LID_W-1:0] lock_id;
    req_type_e        req_type;
  } req_t;

  typedef struct packed {
    logic [LEFT_W-1:0] waiters_left;
    logic [ID_W-1:0]   woken_id;
    status_e           status;
  } res_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  id;
  } waiter_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    waiter_t           wr_data;
  } ram_req_t;

  function automatic logic [LEFT_W-1:0] to_left(input logic [CNT_W-1:0] cnt);
    return LEFT_W'(cnt);
  endfunction

endpackage

@@ rtl/priority_mutex_lock_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_mutex_lock_manager
// mutexes with priority ordered wait queues, one status beat per request beat
// ----------------------------------------------------------------------------
//  channel | dir | beat contents (lowest bit first)
//  in_*    | in  | req_type, lock_id, proc_id, proc_priority
//  out_*   | out | status, woken_id, waiters_left
//
//  one request at a time; acquire, queue, drop, idle release, non-holder and
//  invalid lock requests pass the decide state and the result register on to
//  the output register; a handover scans the queue through the single ram
//  read port and then compacts it behind the woken entry
//  synchronous active-low reset empties all locks and queues at once
//  a stalled output holds its beat while the next request may be accepted
// ----------------------------------------------------------------------------
module priority_mutex_lock_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // req_type, lock_id, proc_id, proc_priority
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, woken_id, waiters_left
);
  import pmlm_pkg::*;

  req_t     req;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  ram_req_t ram_req;
  waiter_t  ram_rd_data;
  res_t     out_r;
  logic     out_valid_r;

  assign req.req_type      = req_type_e'(in_tdata[0]);
  assign req.lock_id       = in_tdata[2:1];
  assign req.proc_id       = in_tdata[10:3];
  assign req.proc_priority = in_tdata[18:11];

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.waiters_left, out_r.woken_id, out_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  pmlm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req         (req),
    .req_ready   (in_tready),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  pmlm_queue_ram u_queue_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

@@ rtl/pmlm_queue_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmlm_queue_ram
// wait queue store of all locks, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pmlm_queue_ram (
  input  logic               clk,
  input  pmlm_pkg::ram_req_t req,
  output pmlm_pkg::waiter_t  rd_data
);
  import pmlm_pkg::*;

  waiter_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/pmlm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmlm_ctrl
// lock table and request sequencer: decide, priority scan, queue compaction
// ----------------------------------------------------------------------------
module pmlm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  pmlm_pkg::req_t     req,
  output logic               req_ready,
  output logic               res_valid,
  output pmlm_pkg::res_t     res,
  input  logic               res_ready,
  output pmlm_pkg::ram_req_t ram_req,
  input  pmlm_pkg::waiter_t  ram_rd_data
);
  import pmlm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t            state_r;
  req_t              req_r;
  res_t              res_r;
  logic              busy_r  [NUM_LOCKS];
  logic [ID_W-1:0]   owner_r [NUM_LOCKS];
  logic [CNT_W-1:0]  cnt_r   [NUM_LOCKS];
  logic [CNT_W-1:0]  idx_r;
  logic              dv_r;
  logic [IDX_W-1:0]  dv_idx_r;
  logic [PRI_W-1:0]  best_r;
  logic [IDX_W-1:0]  sel_r;
  logic [ID_W-1:0]   woken_r;

  logic              lk_ok;
  logic [LOCK_W-1:0] lk_idx;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  cnt_cur;
  logic              busy_cur;
  logic [ID_W-1:0]   owner_cur;
  logic              rd_more;
  logic              take;
  logic [IDX_W-1:0]  sel_cur;
  logic [ID_W-1:0]   woken_cur;
  logic              scan_last;

  assign lk_ok     = 32'(req_r.lock_id) < NUM_LOCKS;
  assign lk_idx    = lk_ok ? LOCK_W'(req_r.lock_id) : '0;
  assign base      = ADDR_W'(lk_idx) * ADDR_W'(QUEUE_DEPTH);
  assign cnt_cur   = cnt_r[lk_idx];
  assign busy_cur  = busy_r[lk_idx];
  assign owner_cur = owner_r[lk_idx];
  assign rd_more   = idx_r < cnt_cur;

  assign take      = dv_r && ((dv_idx_r == '0) || (ram_rd_data.pri > best_r));
  assign sel_cur   = take ? dv_idx_r : sel_r;
  assign woken_cur = take ? ram_rd_data.id : woken_r;
  assign scan_last = dv_r && (CNT_W'(dv_idx_r) == cnt_cur - CNT_W'(1));

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

  always_comb begin
    ram_req         = '0;
    ram_req.rd_addr = base + ADDR_W'(idx_r[IDX_W-1:0]);
    case (state_r)
      S_DECIDE: begin
        ram_req.wr_en        = lk_ok && req_r.req_type == REQ_WAIT && busy_cur &&
                               cnt_cur < CNT_W'(QUEUE_DEPTH);
        ram_req.wr_addr      = base + ADDR_W'(cnt_cur[IDX_W-1:0]);
        ram_req.wr_data.pri  = req_r.proc_priority;
        ram_req.wr_data.id   = req_r.proc_id;
      end
      S_SCAN: begin
        ram_req.rd_en = rd_more;
      end
      S_SHIFT: begin
        ram_req.rd_en   = rd_more;
        ram_req.wr_en   = dv_r;
        ram_req.wr_addr = base + ADDR_W'(dv_idx_r);
        ram_req.wr_data = ram_rd_data;
      end
      default: begin
        ram_req.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dv_r    <= 1'b0;
      for (int i = 0; i < NUM_LOCKS; i++) begin
        busy_r[i]  <= 1'b0;
        owner_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            req_r   <= req;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_r.woken_id <= '0;
          idx_r          <= '0;
          dv_r           <= 1'b0;
          if (!lk_ok) begin
            res_r.status       <= ST_INVALID;
            res_r.waiters_left <= '0;
            state_r            <= S_RESULT;
          end else if (req_r.req_type == REQ_WAIT) begin
            state_r <= S_RESULT;
            if (!busy_cur) begin
              busy_r[lk_idx]     <= 1'b1;
              owner_r[lk_idx]    <= req_r.proc_id;
              res_r.status       <= ST_ACQUIRED;
              res_r.waiters_left <= to_left(cnt_cur);
            end else if (cnt_cur < CNT_W'(QUEUE_DEPTH)) begin
              cnt_r[lk_idx]      <= cnt_cur + CNT_W'(1);
              res_r.status       <= ST_QUEUED;
              res_r.waiters_left <= to_left(cnt_cur + CNT_W'(1));
            end else begin
              res_r.status       <= ST_FULL;
              res_r.waiters_left <= to_left(cnt_cur);
            end
          end else if (!busy_cur || owner_cur != req_r.proc_id) begin
            res_r.status       <= ST_NOT_HOLDER;
            res_r.waiters_left <= to_left(cnt_cur);
            state_r            <= S_RESULT;
          end else if (cnt_cur == '0) begin
            busy_r[lk_idx]     <= 1'b0;
            owner_r[lk_idx]    <= '0;
            res_r.status       <= ST_RELEASED;
            res_r.waiters_left <= to_left(cnt_cur);
            state_r            <= S_RESULT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          dv_idx_r <= idx_r[IDX_W-1:0];
          if (take) begin
            best_r <= ram_rd_data.pri;
          end
          sel_r   <= sel_cur;
          woken_r <= woken_cur;
          if (scan_last) begin
            idx_r   <= CNT_W'(sel_cur) + CNT_W'(1);
            dv_r    <= 1'b0;
            state_r <= S_SHIFT;
          end else begin
            if (rd_more) begin
              idx_r <= idx_r + CNT_W'(1);
            end
            dv_r <= rd_more;
          end
        end
        S_SHIFT: begin
          if (rd_more) begin
            idx_r <= idx_r + CNT_W'(1);
          end
          dv_r     <= rd_more;
          dv_idx_r <= IDX_W'(idx_r - CNT_W'(1));
          if (!rd_more && !dv_r) begin
            cnt_r[lk_idx]      <= cnt_cur - CNT_W'(1);
            owner_r[lk_idx]    <= woken_r;
            res_r.status       <= ST_HANDOVER;
            res_r.woken_id     <= woken_r;
            res_r.waiters_left <= to_left(cnt_cur - CNT_W'(1));
            state_r            <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_priority_mutex_lock_manager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_mutex_lock_manager
// self-checking bench for the priority mutex lock manager. a directed burst
// covers invalid locks, releases by non-holders, owner re-waits, priority ties
// and a full wait queue. random request streams follow, randomly biased
// towards filling or draining the queues, in four flow-control phases. every
// status beat is checked field by field against a behavioural lock model
// ----------------------------------------------------------------------------
module tb_priority_mutex_lock_manager;
  import pmlm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_BEATS = 2000;
  localparam int NUM_PHASES   = 4;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    req_t req;
    res_t res;
  } lock_beat_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // lock state as the block should hold it
  logic             mtx_held  [NUM_LOCKS];
  logic [ID_W-1:0]  mtx_owner [NUM_LOCKS];
  logic [ID_W-1:0]  wq_id     [NUM_LOCKS][QUEUE_DEPTH];
  logic [PRI_W-1:0] wq_pri    [NUM_LOCKS][QUEUE_DEPTH];
  int unsigned      wq_len    [NUM_LOCKS];

  lock_beat_t  pending_reqs[$];
  res_t        due_status[$];
  lock_beat_t  cur_beat;
  logic        in_taken       = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;
  int unsigned errors         = 0;
  int unsigned sent           = 0;
  int unsigned checked        = 0;
  int unsigned status_seen [8] = '{default: 0};

  priority_mutex_lock_manager u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic res_t mutex_step(input req_t r);
    res_t             o;
    int unsigned      lk;
    int unsigned      n;
    int unsigned      sel;
    logic [PRI_W-1:0] best;
    o.status       = ST_INVALID;
    o.woken_id     = '0;
    o.waiters_left = '0;
    if (r.lock_id >= NUM_LOCKS) begin
      return o;
    end
    lk             = r.lock_id;
    n              = wq_len[lk];
    o.waiters_left = LEFT_W'(n);
    if (r.req_type == REQ_WAIT) begin
      if (!mtx_held[lk]) begin
        mtx_held[lk]  = 1'b1;
        mtx_owner[lk] = r.proc_id;
        o.status      = ST_ACQUIRED;
      end else if (n < QUEUE_DEPTH) begin
        wq_id[lk][n]   = r.proc_id;
        wq_pri[lk][n]  = r.proc_priority;
        wq_len[lk]     = n + 1;
        o.status       = ST_QUEUED;
        o.waiters_left = LEFT_W'(n + 1);
      end else begin
        o.status = ST_FULL;
      end
    end else if (!mtx_held[lk] || mtx_owner[lk] != r.proc_id) begin
      o.status = ST_NOT_HOLDER;
    end else if (n == 0) begin
      mtx_held[lk]  = 1'b0;
      mtx_owner[lk] = '0;
      o.status      = ST_RELEASED;
    end else begin
      // first waiter with the strictly highest priority wins
      sel  = 0;
      best = wq_pri[lk][0];
      for (int unsigned i = 1; i < n; i++) begin
        if (wq_pri[lk][i] > best) begin
          best = wq_pri[lk][i];
          sel  = i;
        end
      end
      o.woken_id = wq_id[lk][sel];
      for (int unsigned i = sel; i + 1 < n; i++) begin
        wq_id[lk][i]  = wq_id[lk][i + 1];
        wq_pri[lk][i] = wq_pri[lk][i + 1];
      end
      wq_len[lk]     = n - 1;
      mtx_owner[lk]  = o.woken_id;
      o.status       = ST_HANDOVER;
      o.waiters_left = LEFT_W'(n - 1);
    end
    return o;
  endfunction

  task automatic send_req(input req_type_e rt, input int unsigned lk,
                          input int unsigned pid, input int unsigned pri);
    lock_beat_t b;
    b.req.req_type      = rt;
    b.req.lock_id       = LID_W'(lk);
    b.req.proc_id       = ID_W'(pid);
    b.req.proc_priority = PRI_W'(pri);
    b.res               = mutex_step(b.req);
    pending_reqs.push_back(b);
  endtask

  task automatic send_random(input int unsigned grow_pct);
    int unsigned lk;
    int unsigned pid;
    int unsigned pri;
    int unsigned roll;
    lk   = ($urandom_range(99) < 4) ? NUM_LOCKS : $urandom_range(NUM_LOCKS - 1);
    pid  = $urandom_range(255);
    roll = $urandom_range(99);
    if (roll < 40) begin
      pri = $urandom_range(3);
    end else if (roll < 50) begin
      pri = (roll < 45) ? 0 : 255;
    end else begin
      pri = $urandom_range(255);
    end
    roll = $urandom_range(99);
    if (roll < grow_pct) begin
      if (lk < NUM_LOCKS && mtx_held[lk] && $urandom_range(9) == 0) begin
        pid = mtx_owner[lk];
      end
      send_req(REQ_WAIT, lk, pid, pri);
    end else begin
      // mostly releases by the holder, a few from strangers
      if (lk < NUM_LOCKS && mtx_held[lk] && roll < 93) begin
        pid = mtx_owner[lk];
      end
      send_req(REQ_SIGNAL, lk, pid, pri);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_beat = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_DATA_W'(cur_beat.req);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // status monitor and checker
  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_priority_mutex_lock_manager failed");
      $finish;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (rst_n && out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (due_status.size() == 0) begin
          $error("status beat %h with nothing outstanding", out_tdata);
          errors++;
        end else begin
          want = due_status.pop_front();
          checked++;
          status_seen[want.status]++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.woken_id !== want.woken_id) begin
            $error("woken_id: expected %0d, got %0d", want.woken_id, got.woken_id);
            errors++;
          end
          if (got.waiters_left !== want.waiters_left) begin
            $error("waiters_left: expected %0d, got %0d", want.waiters_left,
                   got.waiters_left);
            errors++;
          end
        end
      end
      if (rst_n && in_tvalid && in_tready) begin
        due_status.push_back(cur_beat.res);
        sent++;
      end
    end
  end

  initial begin
    int unsigned grow;
    for (int l = 0; l < NUM_LOCKS; l++) begin
      mtx_held[l]  = 1'b0;
      mtx_owner[l] = '0;
      wq_len[l]    = 0;
    end
    grow = 55;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      if (ph == 0) begin
        send_req(REQ_WAIT, NUM_LOCKS, 255, 255);
        send_req(REQ_SIGNAL, NUM_LOCKS, 0, 0);
        send_req(REQ_SIGNAL, 0, 0, 0);
        send_req(REQ_WAIT, 0, 0, 0);
        send_req(REQ_WAIT, 0, 0, 0);
        send_req(REQ_WAIT, 0, 255, 255);
        send_req(REQ_WAIT, 0, 7, 255);
        send_req(REQ_SIGNAL, 0, 9, 255);
        send_req(REQ_SIGNAL, 0, 0, 0);
        send_req(REQ_WAIT, 2, 1, 0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          send_req(REQ_WAIT, 2, 100 + i, (i * 16) % 256);
        end
        send_req(REQ_WAIT, 2, 200, 255);
      end
      for (int k = 0; k < RANDOM_BEATS / NUM_PHASES; k++) begin
        // pick at random a bias towards filling or draining the queues
        if (k % 100 == 0) begin
          case ($urandom_range(2))
            0:       grow = 30;
            1:       grow = 55;
            default: grow = 75;
          endcase
        end
        send_random(grow);
      end
      while (pending_reqs.size() != 0) @(posedge clk);
    end
    while (in_tvalid) @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d request beats sent, %0d status beats checked in %0d cycles",
             sent, checked, cycles);
    $display("acq %0d, queued %0d, full %0d, idle rel %0d, handover %0d, %s %0d, %s %0d",
             status_seen[ST_ACQUIRED], status_seen[ST_QUEUED], status_seen[ST_FULL],
             status_seen[ST_RELEASED], status_seen[ST_HANDOVER], "non-holder",
             status_seen[ST_NOT_HOLDER], "bad lock", status_seen[ST_INVALID]);
    if (errors == 0 && due_status.size() == 0) begin
      $display("tb_priority_mutex_lock_manager passed");
    end else begin
      $display("tb_priority_mutex_lock_manager failed");
    end
    $finish;
  end

endmodule
